// ===== sv/signed_int_to_decimal_ascii_top_defines.svh =====
// ----------------------------------------------------------------------------
// itoa assertion macros
// shared concurrent assertion wrappers, removed when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ITOA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITOA_ASSERT(lbl, prop, msg) \
  `ITOA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ITOA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ITOA_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== sv/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa package
// constants, stage type and double-dabble step for the decimal text converter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  localparam int ValueWidth    = 32;
  localparam int NumDigits     = 10;
  localparam int DigitIdxW     = $clog2(NumDigits);
  localparam int StageCount    = 5;
  localparam int StepsPerStage = ValueWidth / (StageCount - 1);

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [3:0] DigitNine = 4'd9;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                  neg;
    bcd_t                  bcd;
    logic [ValueWidth-1:0] mag;
  } conv_t;

  // one slice of the shift-and-add-3 conversion
  function automatic conv_t dabble_steps(input conv_t c);
    conv_t r;
    r = c;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (r.bcd[d] >= 4'd5) begin
          r.bcd[d] = r.bcd[d] + 4'd3;
        end
      end
      {r.bcd, r.mag} = {r.bcd, r.mag} << 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii_top.sv =====
// a started number passes through the stage registers into the serialiser; its
//   first character waits while an earlier text is still going out
// throughput: one character per cycle while a text goes out; an item is 1 to 11
//   characters (sign plus digits), sent through the single-character result port
// a capture stage, four double-dabble stages of 8 bits each, then the serialiser
// reset clears all valid bits; the receiver cannot stall, busy_o holds off input
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// signed 32-bit integer to decimal ascii, one character per strobe
// ----------------------------------------------------------------------------
`default_nettype none

`include "signed_int_to_decimal_ascii_top_defines.svh"

module signed_int_to_decimal_ascii_top
  import itoa_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [ValueWidth-1:0] value_i,
  output logic                              strobe_o,
  output logic             [7:0]            text_char_o,
  output logic                              is_last_o
);

  localparam int Last = StageCount - 1;

  logic [StageCount-1:0] vld_q, vld_d;
  logic [StageCount-1:0] adv;
  conv_t                 stage_q [StageCount];
  conv_t                 stage_d [StageCount];

  logic                  ser_vld_q, ser_vld_d;
  logic                  ser_sign_q, ser_sign_d;
  logic [DigitIdxW-1:0]  ser_idx_q, ser_idx_d;
  bcd_t                  ser_bcd_q, ser_bcd_d;
  logic                  ser_ready;
  logic [DigitIdxW-1:0]  msd;
  logic [ValueWidth-1:0] raw;

  assign raw = value_i;

  // output side, straight from the serialiser registers
  assign strobe_o    = ser_vld_q;
  assign is_last_o   = ser_vld_q && !ser_sign_q && (ser_idx_q == '0);
  assign text_char_o = ser_sign_q ? CharMinus : (CharZero + {4'b0000, ser_bcd_q[ser_idx_q]});
  assign ser_ready   = !ser_vld_q || is_last_o;

  // a stage moves on when its successor is empty or moving on too
  always_comb begin
    adv[Last] = !vld_q[Last] || ser_ready;
    for (int i = Last - 1; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign busy_o = !adv[0];

  always_comb begin
    vld_d[0]          = start_i;
    stage_d[0].neg    = raw[ValueWidth-1];
    stage_d[0].bcd    = '0;
    stage_d[0].mag    = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;
    for (int i = 1; i < StageCount; i++) begin
      vld_d[i]   = vld_q[i-1];
      stage_d[i] = dabble_steps(stage_q[i-1]);
    end
  end

  // most significant non-zero digit, zero itself gives index zero
  always_comb begin
    msd = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (stage_q[Last].bcd[d] != 4'd0) begin
        msd = DigitIdxW'(d);
      end
    end
  end

  always_comb begin
    ser_vld_d  = ser_vld_q;
    ser_sign_d = ser_sign_q;
    ser_idx_d  = ser_idx_q;
    ser_bcd_d  = ser_bcd_q;
    if (ser_ready) begin
      ser_vld_d  = vld_q[Last];
      ser_sign_d = stage_q[Last].neg;
      ser_idx_d  = msd;
      ser_bcd_d  = stage_q[Last].bcd;
    end else if (ser_sign_q) begin
      ser_sign_d = 1'b0;
    end else begin
      ser_idx_d = ser_idx_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      ser_vld_q <= 1'b0;
    end else begin
      for (int i = 0; i < StageCount; i++) begin
        if (adv[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
      ser_vld_q <= ser_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < StageCount; i++) begin
      if (adv[i]) begin
        stage_q[i] <= stage_d[i];
      end
    end
    ser_sign_q <= ser_sign_d;
    ser_idx_q  <= ser_idx_d;
    ser_bcd_q  <= ser_bcd_d;
  end

  // a text runs without gaps until its last character
  `ITOA_ASSERT(a_no_gap, strobe_o && !is_last_o |=> strobe_o, "gap inside a text")

  // the final character is always a digit
  `ITOA_ASSERT(a_last_digit, is_last_o |-> (text_char_o >= CharZero) && (text_char_o <= (CharZero + {4'b0000, DigitNine})), "last character not a digit")

  // a stalled last stage keeps its item
  `ITOA_ASSERT(a_stall_hold, vld_q[Last] && !ser_ready |=> vld_q[Last] && $stable(stage_q[Last]), "stalled item lost")

  // the first digit of a multi-digit text is never zero
  `ITOA_ASSERT(a_no_lead_zero, strobe_o && !is_last_o && (text_char_o != CharMinus) && (!$past(strobe_o) || $past(is_last_o) || ($past(text_char_o) == CharMinus)) |-> (text_char_o != CharZero), "leading zero")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top testbench
// feeds signed 32-bit numbers through the start/busy handshake and checks each
// strobed character and its last flag against decimal text worked out here
// ----------------------------------------------------------------------------
module testbench;
  import itoa_pkg::ValueWidth;
  import itoa_pkg::CharMinus;
  import itoa_pkg::CharZero;

  localparam int CycleLimit  = 200000;
  localparam int SettleTail  = 20;
  localparam int CalmTail    = 25;  // last numbers go without idle bursts
  localparam int RandomCount = 100;

  typedef struct {
    bit                           wait_idle;  // hold off until all text is out
    logic signed [ValueWidth-1:0] value;
  } feed_item_t;

  typedef struct {
    logic [7:0] text_char;
    logic       is_last;
  } text_char_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic signed [ValueWidth-1:0] value_i = '0;
  logic                         busy_o;
  logic                         strobe_o;
  logic [7:0]                   text_char_o;
  logic                         is_last_o;

  feed_item_t number_feed[$];
  text_char_t expected_text[$];

  int  errors = 0;
  int  numbers_sent = 0;
  int  negatives_sent = 0;
  int  chars_checked = 0;
  int  idle_waits = 0;
  int  cycle_count = 0;
  int  idle_left = 0;
  bit  next_start;
  feed_item_t head;
  text_char_t want;

  signed_int_to_decimal_ascii_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .text_char_o(text_char_o),
    .is_last_o  (is_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // decimal text of one number, sign first, digits most significant first
  task automatic queue_decimal_text(input logic signed [ValueWidth-1:0] v);
    logic [ValueWidth:0] mag;
    logic [3:0]          digits[10];
    int                  ndig;
    text_char_t          c;
    mag  = v[ValueWidth-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % 10);
      mag          = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < 10);
    if (v[ValueWidth-1]) begin
      c.text_char = CharMinus;
      c.is_last   = 1'b0;
      expected_text.push_back(c);
      negatives_sent++;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      c.text_char = CharZero + 8'(digits[k]);
      c.is_last   = (k == 0);
      expected_text.push_back(c);
    end
  endtask

  // mostly numbers of a random digit count, now and then a raw 32-bit word
  function automatic logic signed [ValueWidth-1:0] random_number();
    longint lo, hi, mag;
    int     ndig;
    bit     neg;
    if ($urandom_range(4) == 0) begin
      return $urandom;
    end
    ndig = $urandom_range(10, 1);
    lo   = 1;
    for (int i = 1; i < ndig; i++) begin
      lo = lo * 10;
    end
    hi = (ndig == 10) ? 64'd2147483648 : lo * 10 - 1;
    if (ndig == 1) begin
      lo = 0;
    end
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    neg = $urandom_range(1);
    if (!neg && mag > 64'd2147483647) begin
      mag = 64'd2147483647;
    end
    return neg ? ValueWidth'(-mag) : ValueWidth'(mag);
  endfunction

  task automatic feed(input logic signed [ValueWidth-1:0] v);
    feed_item_t it;
    it.wait_idle = 1'b0;
    it.value     = v;
    number_feed.push_back(it);
  endtask

  task automatic feed_pause();
    feed_item_t it;
    it.wait_idle = 1'b1;
    it.value     = '0;
    number_feed.push_back(it);
  endtask

  // driver: a number is taken at the edge where start is high and busy is low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      value_i   <= '0;
      idle_left = 0;
    end else begin
      next_start = start_i;
      if (start_i && !busy_o) begin
        queue_decimal_text(value_i);
        numbers_sent++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (number_feed.size() != 0) begin
          if (number_feed[0].wait_idle) begin
            if (expected_text.size() == 0) begin
              void'(number_feed.pop_front());
              idle_waits++;
            end
          end else if (number_feed.size() > CalmTail && $urandom_range(3) == 0) begin
            idle_left = $urandom_range(11, 1) - 1;  // this cycle is the first idle one
          end else begin
            head = number_feed.pop_front();
            value_i   <= head.value;
            next_start = 1'b1;
          end
        end
      end
      start_i <= next_start;
    end
  end

  // monitor: every strobe is one character transfer, no back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (expected_text.size() == 0) begin
        errors++;
        $display("%0t: unexpected character: expected none, got char %0d last %0b",
                 $time, text_char_o, is_last_o);
      end else begin
        want = expected_text.pop_front();
        chars_checked++;
        if (text_char_o !== want.text_char) begin
          errors++;
          $display("%0t: text_char mismatch: expected %0d, got %0d",
                   $time, want.text_char, text_char_o);
        end
        if (is_last_o !== want.is_last) begin
          errors++;
          $display("%0t: is_last mismatch: expected %0b, got %0b",
                   $time, want.is_last, is_last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d characters still outstanding", $time,
               expected_text.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // zero, single digits, powers of ten and both ends of the range
    feed(0);
    feed(1);
    feed(-1);
    feed(9);
    feed(-9);
    feed(10);
    feed(-10);
    feed(99);
    feed(100);
    feed(1000000000);
    feed(999999999);
    feed(-999999999);
    feed(123456789);
    feed(-1234567890);
    feed(32'h7fffffff);
    feed(32'h80000000);
    feed(32'h80000001);
    feed(32'h55555555);
    feed(32'haaaaaaaa);
    feed(-100000);
    feed_pause();
    for (int i = 0; i < RandomCount; i++) begin
      if (i == RandomCount / 2) begin
        feed_pause();
      end
      feed(random_number());
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (number_feed.size() != 0 || start_i || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleTail) @(posedge clk_i);

    $display("converted %0d numbers (%0d negative), checked %0d characters",
             numbers_sent, negatives_sent, chars_checked);
    $display("drained the converter %0d times mid-run, %0d errors", idle_waits, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
